// File: sv/sky_cloud_segment_vote_filter_macros.svh
// Assertion macros for the sky / cloud vote filter.
// Used by the top level; expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef SKY_CLOUD_SEGMENT_VOTE_FILTER_MACROS_SVH
`define SKY_CLOUD_SEGMENT_VOTE_FILTER_MACROS_SVH

// Same-cycle implication
`define SCSVF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scsvf assertion failed");

// Next-cycle implication
`define SCSVF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scsvf assertion failed");

`endif

// File: sv/scsvf_pkg.sv
// Shared types and constants of the sky / cloud vote filter.
// No dependencies.
`timescale 1ns / 1ps

package scsvf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_WINDOW = 7;
    localparam int ROW_W          = 10;
    localparam int POS_W          = 10;
    localparam int CFG_DIM_W      = 11;
    localparam int RATIO_W        = 17;
    localparam int VOTES_W        = 6;
    localparam int HALF_CFG_W     = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 17;
    localparam int MAX_HEIGHT     = 1024;

    typedef enum logic [1:0] {
        CLS_OUTSIDE = 2'd0,
        CLS_SKY     = 2'd1,
        CLS_CLOUD   = 2'd2
    } t_class;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATIO  = 3'd0,
        CFG_HALF   = 3'd1,
        CFG_VOTES  = 3'd2,
        CFG_WIDTH  = 3'd3,
        CFG_HEIGHT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic [1:0]       pixel_class;
        logic             was_flipped;
        logic             frame_last;
    } t_out_item;

    // Control that every window cell receives
    typedef struct packed {
        logic   shift;
        t_class centre;
    } t_cell_ctrl;

endpackage

// File: sv/sky_cloud_segment_vote_filter.sv
// Top level of the sky / cloud vote filter: classifier, line RAM, cell window, vote tree.
// Depends on scsvf_pkg, scsvf_ram, scsvf_cell and the macros header.
//
//  channel | direction | handshake             | payload
//  in      | input     | i_in_valid/o_in_stall | i_in_data  (t_in_item)
//  out     | output    | o_out_valid/i_out_stall | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One pixel per clock; a result passes stages 1, 2 and 3, then the output register.
// The single pipeline enable follows the output register: an output stall holds every stage.
// The line RAM is read and written back once per pixel; a same-column repeat is forwarded.
// Reset is synchronous; no clearing pass is needed.
`timescale 1ns / 1ps

`include "sky_cloud_segment_vote_filter_macros.svh"

module sky_cloud_segment_vote_filter
    import scsvf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WC_W     = COL_W + 1;
    localparam int CW       = (WC_W > CFG_DIM_W) ? WC_W : CFG_DIM_W;
    localparam int LINES    = MAX_WINDOW - 1;
    localparam int SLOT_W   = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int MAX_HALF = (MAX_WINDOW - 1) / 2;
    localparam int RC_W     = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int VW       = (CNT_W > VOTES_W) ? CNT_W : VOTES_W;

    // Configuration registers
    logic [RATIO_W-1:0]    r_ratio;
    logic [HALF_CFG_W-1:0] r_half;
    logic [VOTES_W-1:0]    r_votes;
    logic [CFG_DIM_W-1:0]  r_width;
    logic [CFG_DIM_W-1:0]  r_height;

    // Position counters
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [SLOT_W-1:0] r_slot, n_slot;

    logic en, in_acc;

    // Stage 1
    logic              r_s1_valid;
    logic [COL_W-1:0]  r_s1_col;
    logic [SLOT_W-1:0] r_s1_slot;
    t_class            r_s1_cls;
    logic              r_s1_interior;
    logic [POS_W-1:0]  r_s1_orow, r_s1_ocol;
    logic              r_s1_last;

    // Stage 2
    logic             r_s2_valid;
    logic [POS_W-1:0] r_s2_orow, r_s2_ocol;
    logic             r_s2_last;

    // Stage 3
    logic             r_s3_valid;
    logic [POS_W-1:0] r_s3_orow, r_s3_ocol;
    logic             r_s3_last;
    t_class           r_s3_centre;
    logic [RC_W-1:0]  r_s3_rowcnt [MAX_WINDOW];

    // Output register
    logic      r_out_valid;
    t_out_item r_out;

    // Forwarding of the last write-back
    logic               r_fwd_valid;
    logic [COL_W-1:0]   r_fwd_addr;
    logic [2*LINES-1:0] r_fwd_word;

    // Effective sizes
    logic [CW-1:0]    w_ext, h_ext;
    logic [WC_W-1:0]  w_eff;
    logic [CFG_DIM_W-1:0] h_eff;
    logic [2:0]       half;
    logic [3:0]       two_h, side;

    // Stage 0 signals
    logic [CFG_DIM_W-1:0] cur_row, nx_row;
    logic [WC_W-1:0]      cur_col, nx_col;
    logic [SLOT_W-1:0]    cur_slot, nx_slot;
    t_class               cls0;
    logic                 s0_interior, s0_last;
    logic [CW-1:0]        ocol_full;
    logic [CFG_DIM_W-1:0] orow_full;

    // Stage 1 signals
    logic [2*LINES-1:0] rd_word, line_word, wr_word;
    t_class             newcol [MAX_WINDOW];

    // Window
    t_class     w_cls  [MAX_WINDOW][MAX_WINDOW];
    logic       w_diff [MAX_WINDOW][MAX_WINDOW];
    t_cell_ctrl cell_ctrl;
    t_class     centre;
    logic [RC_W-1:0] rowcnt [MAX_WINDOW];

    // Stage 3 signals
    logic [CNT_W-1:0] votes_sum;
    t_class           res_cls;
    logic             res_flip;

    assign en          = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !en;
    assign in_acc      = i_in_valid && en;
    assign o_cfg_ready = 1'b1;

    // Configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio  <= '0;
            r_half   <= HALF_CFG_W'(1);
            r_votes  <= VOTES_W'(5);
            r_width  <= CFG_DIM_W'(1024);
            r_height <= CFG_DIM_W'(1024);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RATIO:  r_ratio  <= i_cfg_data[RATIO_W-1:0];
                CFG_HALF:   r_half   <= i_cfg_data[HALF_CFG_W-1:0];
                CFG_VOTES:  r_votes  <= i_cfg_data[VOTES_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[CFG_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate sizes and window
    always_comb begin
        w_ext = CW'(r_width);
        if (w_ext == '0) begin
            w_ext = CW'(1);
        end else if (w_ext > CW'(MAX_WIDTH)) begin
            w_ext = CW'(MAX_WIDTH);
        end
        w_eff = WC_W'(w_ext);
        h_ext = CW'(r_height);
        if (h_ext == '0) begin
            h_ext = CW'(1);
        end else if (h_ext > CW'(MAX_HEIGHT)) begin
            h_ext = CW'(MAX_HEIGHT);
        end
        h_eff = CFG_DIM_W'(h_ext);
        half  = (3'(r_half) > 3'(MAX_HALF)) ? 3'(MAX_HALF) : 3'(r_half);
        two_h = {half, 1'b0};
        side  = two_h + 4'd1;
    end

    // Stage 0: place the pixel, classify, work out the emitted position
    always_comb begin
        cur_row  = CFG_DIM_W'(r_row);
        cur_col  = WC_W'(r_col);
        cur_slot = r_slot;
        if (i_in_data.frame_start) begin
            cur_row  = '0;
            cur_col  = '0;
            cur_slot = '0;
        end else begin
            if (cur_col >= w_eff) begin
                cur_col  = '0;
                cur_row  = cur_row + 1'b1;
                cur_slot = (cur_slot == SLOT_W'(LINES - 1)) ? '0 : cur_slot + 1'b1;
            end
            if (cur_row >= h_eff) begin
                cur_row  = '0;
                cur_slot = '0;
            end
        end

        nx_col  = cur_col + 1'b1;
        nx_row  = cur_row;
        nx_slot = cur_slot;
        if (nx_col >= w_eff) begin
            nx_col  = '0;
            nx_row  = cur_row + 1'b1;
            nx_slot = (cur_slot == SLOT_W'(LINES - 1)) ? '0 : cur_slot + 1'b1;
            if (nx_row >= h_eff) begin
                nx_row  = '0;
                nx_slot = '0;
            end
        end
        n_row  = ROW_W'(nx_row);
        n_col  = COL_W'(nx_col);
        n_slot = nx_slot;

        if (i_in_data.red == '0 && i_in_data.green == '0 && i_in_data.blue == '0) begin
            cls0 = CLS_OUTSIDE;
        end else if (25'({i_in_data.red, 16'd0}) < 25'(r_ratio) * 25'(i_in_data.blue)) begin
            cls0 = CLS_SKY;
        end else begin
            cls0 = CLS_CLOUD;
        end

        s0_interior = (cur_row >= CFG_DIM_W'(two_h)) && (CW'(cur_col) >= CW'(two_h));
        s0_last     = (cur_row == h_eff - 1'b1) && (cur_col == w_eff - 1'b1);
        orow_full   = cur_row - CFG_DIM_W'(half);
        ocol_full   = CW'(cur_col) - CW'(half);
    end

    // Advance the position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (in_acc) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_slot <= n_slot;
        end
    end

    // Line RAM: one word per column, one class per stored row
    scsvf_ram #(
        .WIDTH(2 * LINES),
        .DEPTH(MAX_WIDTH)
    ) u_lines (
        .i_clk  (i_clk),
        .i_we   (en && r_s1_valid),
        .i_waddr(r_s1_col),
        .i_wdata(wr_word),
        .i_re   (en),
        .i_raddr(COL_W'(cur_col)),
        .o_rdata(rd_word)
    );

    // Stage 1: gather the new window column, build the write-back word
    always_comb begin
        int idx;
        idx       = 0;
        line_word = (r_fwd_valid && r_fwd_addr == r_s1_col) ? r_fwd_word : rd_word;
        newcol[0] = r_s1_cls;
        for (int k = 1; k < MAX_WINDOW; k++) begin
            idx = (int'(r_s1_slot) >= k) ? int'(r_s1_slot) - k : int'(r_s1_slot) + LINES - k;
            newcol[k] = t_class'(line_word[2*idx +: 2]);
        end
        wr_word = line_word;
        wr_word[2*r_s1_slot +: 2] = r_s1_cls;
    end

    // Pick the centre cell
    always_comb begin
        centre = CLS_OUTSIDE;
        for (int i = 0; i <= MAX_HALF; i++) begin
            if (half == 3'(i)) begin
                centre = w_cls[i][i];
            end
        end
    end

    assign cell_ctrl.shift  = en && r_s1_valid;
    assign cell_ctrl.centre = centre;

    // Window: one chain of cells per row
    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_row
        for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
            scsvf_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (cell_ctrl),
                .i_cls      ((j == 0) ? newcol[k] : w_cls[k][(j > 0) ? j - 1 : 0]),
                .i_in_window((4'(k) < side) && (4'(j) < side)),
                .o_cls      (w_cls[k][j]),
                .o_diff     (w_diff[k][j])
            );
        end
    end

    // Stage 2: count disagreements per window row
    always_comb begin
        for (int k = 0; k < MAX_WINDOW; k++) begin
            rowcnt[k] = '0;
            for (int j = 0; j < MAX_WINDOW; j++) begin
                rowcnt[k] = rowcnt[k] + RC_W'(w_diff[k][j]);
            end
        end
    end

    // Stage 3: total the rows and decide the class
    always_comb begin
        votes_sum = '0;
        for (int k = 0; k < MAX_WINDOW; k++) begin
            votes_sum = votes_sum + CNT_W'(r_s3_rowcnt[k]);
        end
        res_cls  = r_s3_centre;
        res_flip = 1'b0;
        if (r_s3_centre != CLS_OUTSIDE && VW'(votes_sum) >= VW'(r_votes)) begin
            res_flip = 1'b1;
            case (r_s3_centre)
                CLS_SKY:   res_cls = CLS_CLOUD;
                CLS_CLOUD: res_cls = CLS_SKY;
                default:   res_cls = CLS_OUTSIDE;
            endcase
        end
    end

    // Advance pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_in_valid;
            r_s2_valid  <= r_s1_valid && r_s1_interior;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
            r_fwd_valid <= r_s1_valid;
        end
    end

    // Advance pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_col      <= COL_W'(cur_col);
            r_s1_slot     <= cur_slot;
            r_s1_cls      <= cls0;
            r_s1_interior <= s0_interior;
            r_s1_orow     <= orow_full[POS_W-1:0];
            r_s1_ocol     <= ocol_full[POS_W-1:0];
            r_s1_last     <= s0_last;

            r_fwd_addr <= r_s1_col;
            r_fwd_word <= wr_word;

            r_s2_orow <= r_s1_orow;
            r_s2_ocol <= r_s1_ocol;
            r_s2_last <= r_s1_last;

            r_s3_orow   <= r_s2_orow;
            r_s3_ocol   <= r_s2_ocol;
            r_s3_last   <= r_s2_last;
            r_s3_centre <= centre;
            for (int k = 0; k < MAX_WINDOW; k++) begin
                r_s3_rowcnt[k] <= rowcnt[k];
            end

            r_out.out_row     <= r_s3_orow;
            r_out.out_col     <= r_s3_ocol;
            r_out.pixel_class <= res_cls;
            r_out.was_flipped <= res_flip;
            r_out.frame_last  <= r_s3_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    `SCSVF_ASSERT_NOW(a_flip_not_outside, o_out_valid && o_out_data.was_flipped, o_out_data.pixel_class != CLS_OUTSIDE)
    `SCSVF_ASSERT_NOW(a_stall_holds_input, o_out_valid && i_out_stall, o_in_stall)
    `SCSVF_ASSERT_NEXT(a_fwd_follows_write, en && r_s1_valid, r_fwd_valid)

endmodule

// File: sv/scsvf_ram.sv
// Generic single-port-write, registered-read RAM (old data on a read-write collision).
// No dependencies.
`timescale 1ns / 1ps

module scsvf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/scsvf_cell.sv
// One cell of the class window: holds one class, takes its neighbor's on a shift.
// Depends on scsvf_pkg.
`timescale 1ns / 1ps

module scsvf_cell
    import scsvf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_class     i_cls,
    input  logic       i_in_window,
    output t_class     o_cls,
    output logic       o_diff
);

    t_class r_cls;

    // Shift in the neighbor's class
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls <= CLS_OUTSIDE;
        end else if (i_ctrl.shift) begin
            r_cls <= i_cls;
        end
    end

    // Flag disagreement with the centre inside the active window
    assign o_diff = i_in_window && (r_cls != i_ctrl.centre);
    assign o_cls  = r_cls;

endmodule

// File: test/sky_cloud_segment_vote_filter_test.sv
// Self-checking testbench for the sky / cloud vote filter: a queue-fed pixel driver,
// a result monitor and a built-in classifier / vote predictor. Depends on scsvf_pkg.
`timescale 1ns / 1ps

module sky_cloud_segment_vote_filter_test;
    import scsvf_pkg::*;

    localparam int LINE_CNT  = 6;
    localparam int PIX_MAX_W = 1024;
    localparam int CYC_LIMIT = 400000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    sky_cloud_segment_vote_filter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock and run-length guard
    always #10 i_clk = ~i_clk;

    int cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYC_LIMIT) begin
            $display("sky_cloud_segment_vote_filter regression: fail");
            $finish;
        end
    end

    // Predictor state
    logic [1:0]  class_mem [LINE_CNT][PIX_MAX_W];
    logic [1:0]  vote_win  [7][7];
    int unsigned row_cnt, col_cnt;
    logic [16:0] thr_reg;
    logic [1:0]  half_reg;
    logic [5:0]  votes_reg;
    logic [10:0] width_reg, height_reg;

    t_in_item  pixel_q[$];
    t_out_item filtered_q[$];
    int        err_cnt = 0;
    bit        no_idle = 1'b0;
    bit        in_taken = 1'b0;

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_cnt);
        err_cnt++;
    endtask

    function automatic logic [1:0] classify_pixel(t_in_item px);
        longint unsigned lhs, rhs;
        lhs = longint'(px.red) * 65536;
        rhs = longint'(thr_reg) * px.blue;
        if (px.red == 0 && px.green == 0 && px.blue == 0) return CLS_OUTSIDE;
        if (lhs < rhs) return CLS_SKY;
        return CLS_CLOUD;
    endfunction

    // Advance the filter by one pixel; queue the filtered result if one is due
    task automatic predict_pixel(t_in_item px);
        int unsigned w, h, hf, side, row, col, nv;
        logic [1:0]  cls, centre, res;
        logic [1:0]  newcol [7];
        bit          flip;
        t_out_item   o;
        w = width_reg;  if (w == 0) w = 1;  if (w > PIX_MAX_W) w = PIX_MAX_W;
        h = height_reg; if (h == 0) h = 1;  if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        hf = half_reg;
        side = 2 * hf + 1;
        if (px.frame_start) begin
            row_cnt = 0;
            col_cnt = 0;
        end else begin
            if (col_cnt >= w) begin col_cnt = 0; row_cnt++; end
            if (row_cnt >= h) row_cnt = 0;
        end
        row = row_cnt;
        col = col_cnt;
        cls = classify_pixel(px);
        newcol[0] = cls;
        for (int k = 1; k < 7; k++)
            newcol[k] = class_mem[(row + LINE_CNT * MAX_HEIGHT - k) % LINE_CNT][col];
        for (int k = 0; k < 7; k++) begin
            for (int j = 6; j > 0; j--) vote_win[k][j] = vote_win[k][j-1];
            vote_win[k][0] = newcol[k];
        end
        class_mem[row % LINE_CNT][col] = cls;
        if (row >= 2 * hf && col >= 2 * hf) begin
            centre = vote_win[hf][hf];
            res = centre;
            flip = 1'b0;
            nv = 0;
            if (centre != CLS_OUTSIDE) begin
                for (int k = 0; k < side; k++)
                    for (int j = 0; j < side; j++)
                        if (vote_win[k][j] != centre) nv++;
                if (nv >= votes_reg) begin
                    res = 2'd3 - centre;
                    flip = 1'b1;
                end
            end
            o.out_row     = POS_W'(row - hf);
            o.out_col     = POS_W'(col - hf);
            o.pixel_class = res;
            o.was_flipped = flip;
            o.frame_last  = (row == h - 1 && col == w - 1);
            filtered_q.push_back(o);
        end
        col_cnt = col + 1;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt = row + 1;
            if (row_cnt >= h) row_cnt = 0;
        end
    endtask

    // Track transfers: pixels into the predictor, register writes into its settings
    always @(posedge i_clk) begin
        in_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) predict_pixel(i_in_data);
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RATIO:  thr_reg    = i_cfg_data[16:0];
                CFG_HALF:   half_reg   = i_cfg_data[1:0];
                CFG_VOTES:  votes_reg  = i_cfg_data[5:0];
                CFG_WIDTH:  width_reg  = i_cfg_data[10:0];
                CFG_HEIGHT: height_reg = i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (filtered_q.size() == 0) begin
                report_mismatch("unexpected result row", o_out_data.out_row, -1);
            end else begin
                want = filtered_q.pop_front();
                if (o_out_data.out_row != want.out_row)
                    report_mismatch("out_row", o_out_data.out_row, want.out_row);
                if (o_out_data.out_col != want.out_col)
                    report_mismatch("out_col", o_out_data.out_col, want.out_col);
                if (o_out_data.pixel_class != want.pixel_class)
                    report_mismatch("pixel_class", o_out_data.pixel_class, want.pixel_class);
                if (o_out_data.was_flipped != want.was_flipped)
                    report_mismatch("was_flipped", o_out_data.was_flipped, want.was_flipped);
                if (o_out_data.frame_last != want.frame_last)
                    report_mismatch("frame_last", o_out_data.frame_last, want.frame_last);
            end
        end
    end

    // Pixel driver: hold a stalled pixel, otherwise present the next one or idle
    always @(negedge i_clk) begin
        bit       nxt_valid;
        t_in_item nxt_data;
        nxt_valid = i_in_valid;
        nxt_data  = i_in_data;
        if (!i_in_valid || in_taken) begin
            if (pixel_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 25)) begin
                nxt_data  = pixel_q.pop_front();
                nxt_valid = 1'b1;
            end else begin
                nxt_valid = 1'b0;
            end
        end
        i_in_valid <= nxt_valid;
        i_in_data  <= nxt_data;
    end

    // Result-side back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 25);
    end

    task automatic write_reg(t_cfg_idx idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait for the block to drain, then let the pipeline settle
    task automatic wait_idle();
        while (pixel_q.size() > 0 || i_in_valid || filtered_q.size() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_config(int unsigned thr, int unsigned hf, int unsigned vt,
                              int unsigned w, int unsigned h);
        wait_idle();
        write_reg(CFG_RATIO, thr);
        write_reg(CFG_HALF, hf);
        write_reg(CFG_VOTES, vt);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    function automatic t_in_item rand_pixel(bit fs);
        t_in_item p;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        p.red   = $urandom_range(0, 255);
        p.green = $urandom_range(0, 255);
        p.blue  = $urandom_range(0, 255);
        if (sel < 15) begin
            p.red = 0; p.green = 0; p.blue = 0;
        end else if (sel < 22) begin
            p.blue = 0;
        end else if (sel < 30) begin
            p.red = $urandom_range(0, 8);
        end
        p.frame_start = fs;
        return p;
    endfunction

    function automatic t_in_item mk_pixel(int r, int g, int b, bit fs);
        t_in_item p;
        p.red = r; p.green = g; p.blue = b; p.frame_start = fs;
        return p;
    endfunction

    initial begin
        int unsigned rand_items, w, h, hf, nfr, thr, vt, sel, cnt;
        rand_items = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        thr_reg = 0; half_reg = 1; votes_reg = 5; width_reg = 1024; height_reg = 1024;
        row_cnt = 0; col_cnt = 0;
        foreach (class_mem[i, j]) class_mem[i][j] = CLS_OUTSIDE;
        foreach (vote_win[i, j]) vote_win[i][j] = CLS_OUTSIDE;

        // Directed: channel extremes, outside, blue zero, zero votes, ratio 1.0
        set_config(65536, 1, 0, 5, 5);
        pixel_q.push_back(mk_pixel(0, 0, 0, 1));
        pixel_q.push_back(mk_pixel(255, 255, 255, 0));
        pixel_q.push_back(mk_pixel(0, 255, 0, 0));
        pixel_q.push_back(mk_pixel(255, 0, 0, 0));
        pixel_q.push_back(mk_pixel(0, 0, 255, 0));
        pixel_q.push_back(mk_pixel(254, 0, 255, 0));
        pixel_q.push_back(mk_pixel(255, 0, 254, 0));
        pixel_q.push_back(mk_pixel(1, 0, 0, 0));
        pixel_q.push_back(mk_pixel(0, 1, 0, 0));
        pixel_q.push_back(mk_pixel(0, 0, 1, 0));
        pixel_q.push_back(mk_pixel(170, 85, 170, 0));
        pixel_q.push_back(mk_pixel(85, 170, 85, 0));
        for (int i = 0; i < 13; i++) pixel_q.push_back(rand_pixel(0));

        // Degenerate sizes, oversized registers, window that never fits
        set_config(131071, 0, 63, 0, 0);
        for (int i = 0; i < 8; i++) pixel_q.push_back(rand_pixel(i == 0));
        set_config(0, 3, 49, 2047, 2047);
        for (int i = 0; i < 20; i++) pixel_q.push_back(rand_pixel(i == 0));
        set_config(40000, 2, 3, 4, 9);
        for (int i = 0; i < 36; i++) pixel_q.push_back(rand_pixel(i == 0));
        set_config(65536, 0, 1, 1024, 1024);
        for (int i = 0; i < 300; i++) pixel_q.push_back(rand_pixel(i == 0));

        // Random frames, mostly well formed with stray frame starts and cut frames
        while (rand_items < 660) begin
            w  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
            h  = $urandom_range(1, 10);
            hf = $urandom_range(0, 3);
            sel = $urandom_range(0, 3);
            thr = (sel == 0) ? 0 : (sel == 1) ? 65536 : (sel == 2) ? 131071
                : $urandom_range(0, 131071);
            vt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                : $urandom_range(0, (2 * hf + 1) * (2 * hf + 1));
            set_config(thr, hf, vt, w, h);
            no_idle = (rand_items > 250 && rand_items < 450);
            nfr = $urandom_range(1, 3);
            cnt = nfr * w * h;
            if ($urandom_range(0, 4) == 0) cnt = $urandom_range(1, cnt);
            if (cnt > 660 - rand_items) cnt = 660 - rand_items;
            for (int i = 0; i < cnt; i++)
                pixel_q.push_back(rand_pixel(i == 0 || $urandom_range(0, 99) < 3));
            rand_items += cnt;
        end

        // Drain and report
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0 && filtered_q.size() == 0) begin
            $display("sky_cloud_segment_vote_filter regression: pass");
        end else begin
            $display("sky_cloud_segment_vote_filter regression: fail");
        end
        $finish;
    end

endmodule
